FILE: rtl/bia_pkg.sv
package bia_pkg;

   localparam int unsigned ENTRY_W   = 14;
   localparam int unsigned WORD_BITS = 32;
   localparam int unsigned BIT_W     = 5;

   localparam logic [ENTRY_W-1:0] LIMIT_RESET = 14'd8192;

   localparam logic CMD_ALLOC  = 1'b0;
   localparam logic CMD_FREE   = 1'b1;
   localparam logic POOL_INODE = 1'b0;
   localparam logic POOL_BLOCK = 1'b1;

   localparam logic CSR_INODE_LIMIT = 1'b0;
   localparam logic CSR_BLOCK_LIMIT = 1'b1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_FCHK
   } bia_state_type;

   // request as seen by the controller, limit already clamped to the map size
   typedef struct packed {
      logic               cmd;
      logic               pool;
      logic [ENTRY_W-1:0] entry;
      logic [ENTRY_W-1:0] lim;
   } bia_req_type;

   typedef struct packed {
      logic               valid;
      logic [ENTRY_W-1:0] granted;
      logic               failed;
      logic [ENTRY_W-1:0] free_rem;
   } bia_rsp_type;

endpackage

FILE: rtl/bitmap_inode_block_allocator_top.sv
// First-fit allocator over two bitmaps (inodes and blocks), one bit per entry, kept
// as 32-bit words in a single synchronous RAM with the pool as the top address bit.
// Pulse start with busy low to issue a request; exactly one response comes back as a
// one-cycle rsp_valid strobe and cannot be stalled, so sample it when it shows.
// Allocate reads one word per cycle through the RAM read port and takes the lowest
// clear bit below the pool limit, and the response shows in the cycle busy drops. A
// free takes one read-modify-write: busy is high for one cycle and the response shows
// as it drops. A request that fails on its own fields (free out of range, or an empty
// pool) responds in the next cycle without raising busy. After reset the RAM is swept
// to zero over every address of both pools, with busy high; limit writes on the csr
// port are taken at any time, but change them only while no request is outstanding.
// Limits above MAP_BITS act as MAP_BITS.
module bitmap_inode_block_allocator_top #(
   parameter int unsigned MAP_BITS = 8192
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_command,
   input  logic                           req_pool,
   input  logic [bia_pkg::ENTRY_W-1:0]    req_entry_number,
   output logic                           rsp_valid,
   output logic [bia_pkg::ENTRY_W-1:0]    rsp_granted_number,
   output logic                           rsp_failed,
   output logic [bia_pkg::ENTRY_W-1:0]    rsp_free_remaining,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic                           csr_index,
   input  logic [bia_pkg::ENTRY_W-1:0]    csr_wdata
);

   localparam int unsigned EW     = bia_pkg::ENTRY_W;
   localparam int unsigned WORDS  = (MAP_BITS + bia_pkg::WORD_BITS - 1) / bia_pkg::WORD_BITS;
   localparam int unsigned ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;

   logic [EW-1:0] inode_limit_ff, inode_limit_in;
   logic [EW-1:0] block_limit_ff, block_limit_in;
   logic [EW-1:0] lim_raw;
   logic [EW-1:0] lim_eff;

   bia_pkg::bia_req_type req;
   bia_pkg::bia_rsp_type rsp;

   logic [ADDR_W:0]                 mem_raddr;
   logic [ADDR_W:0]                 mem_waddr;
   logic                            mem_we;
   logic [bia_pkg::WORD_BITS-1:0]   mem_rdata;
   logic [bia_pkg::WORD_BITS-1:0]   mem_wdata;

   // limit registers: always ready, index past the list has no target
   assign csr_ready = 1'b1;

   always_comb begin
      inode_limit_in = inode_limit_ff;
      block_limit_in = block_limit_ff;
      if (csr_valid) begin
         unique case (csr_index)
            bia_pkg::CSR_INODE_LIMIT: inode_limit_in = csr_wdata;
            bia_pkg::CSR_BLOCK_LIMIT: block_limit_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inode_limit_ff <= bia_pkg::LIMIT_RESET;
         block_limit_ff <= bia_pkg::LIMIT_RESET;
      end else begin
         inode_limit_ff <= inode_limit_in;
         block_limit_ff <= block_limit_in;
      end
   end

   // select the pool limit and clamp it to the map size
   assign lim_raw = (req_pool == bia_pkg::POOL_BLOCK) ? block_limit_ff : inode_limit_ff;
   assign lim_eff = (32'(lim_raw) > MAP_BITS) ? EW'(MAP_BITS) : lim_raw;

   assign req.cmd   = req_command;
   assign req.pool  = req_pool;
   assign req.entry = req_entry_number;
   assign req.lim   = lim_eff;

   bia_ctrl #(
      .MAP_BITS (MAP_BITS),
      .ADDR_W   (ADDR_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req       (req),
      .busy      (busy),
      .rsp       (rsp),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata)
   );

   bia_map_ram #(
      .AW (ADDR_W + 1)
   ) u_map_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   assign rsp_valid          = rsp.valid;
   assign rsp_granted_number = rsp.granted;
   assign rsp_failed         = rsp.failed;
   assign rsp_free_remaining = rsp.free_rem;

endmodule

FILE: rtl/bia_map_ram.sv
module bia_map_ram #(
   parameter int unsigned AW = 9
) (
   input  logic                            clock,
   input  logic                            we,
   input  logic [AW-1:0]                   waddr,
   input  logic [bia_pkg::WORD_BITS-1:0]   wdata,
   input  logic [AW-1:0]                   raddr,
   output logic [bia_pkg::WORD_BITS-1:0]   rdata
);

   logic [bia_pkg::WORD_BITS-1:0] mem [2**AW];
   logic [bia_pkg::WORD_BITS-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/bia_ctrl.sv
module bia_ctrl #(
   parameter int unsigned MAP_BITS = 8192,
   parameter int unsigned ADDR_W   = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  bia_pkg::bia_req_type              req,
   output logic                              busy,
   output bia_pkg::bia_rsp_type              rsp,
   output logic [ADDR_W:0]                   mem_raddr,
   input  logic [bia_pkg::WORD_BITS-1:0]     mem_rdata,
   output logic                              mem_we,
   output logic [ADDR_W:0]                   mem_waddr,
   output logic [bia_pkg::WORD_BITS-1:0]     mem_wdata
);

   localparam int unsigned EW = bia_pkg::ENTRY_W;
   localparam int unsigned WB = bia_pkg::WORD_BITS;
   localparam int unsigned BW = bia_pkg::BIT_W;

   bia_pkg::bia_state_type state_ff, state_in;

   logic [ADDR_W:0]   clr_cnt_ff, clr_cnt_in;
   logic              cmd_ff, cmd_in;
   logic              pool_ff, pool_in;
   logic [EW-1:0]     idx_ff, idx_in;
   logic [EW-1:0]     lim_ff, lim_in;
   logic [ADDR_W-1:0] scan_word_ff, scan_word_in;
   logic [EW-1:0]     inode_used_ff, inode_used_in;
   logic [EW-1:0]     block_used_ff, block_used_in;
   bia_pkg::bia_rsp_type rsp_ff, rsp_in;

   // request decode
   logic [EW-1:0] req_idx;
   logic          req_in_range;

   // scan datapath
   logic [ADDR_W-1:0] last_word;
   logic              at_last;
   logic [WB-1:0]     tail_mask;
   logic [WB-1:0]     taken_bits;
   logic              found;
   logic [BW-1:0]     zpos;
   logic [EW-1:0]     bit_num;
   logic              free_hit;

   // completion
   logic          done;
   logic          done_failed;
   logic [EW-1:0] done_granted;
   logic          done_pool;
   logic [EW-1:0] done_lim;
   logic [EW-1:0] used_old;
   logic [EW-1:0] used_new;

   assign req_idx = (req.pool == bia_pkg::POOL_BLOCK) ? req.entry : req.entry - EW'(1);

   always_comb begin
      if (req.pool == bia_pkg::POOL_BLOCK) begin
         req_in_range = req.entry < req.lim;
      end else begin
         req_in_range = (req.entry != '0) && (req.entry <= req.lim);
      end
   end

   assign last_word = ADDR_W'((lim_ff - EW'(1)) >> BW);
   assign at_last   = scan_word_ff == last_word;

   // bits past the limit in the last word count as taken
   always_comb begin
      if (at_last && (lim_ff[BW-1:0] != '0)) begin
         tail_mask = (WB'(1) << lim_ff[BW-1:0]) - WB'(1);
      end else begin
         tail_mask = '1;
      end
   end

   assign taken_bits = mem_rdata | ~tail_mask;
   assign found      = taken_bits != '1;

   always_comb begin
      zpos = '0;
      for (int b = WB - 1; b >= 0; b--) begin
         if (!taken_bits[b]) begin
            zpos = BW'(b);
         end
      end
   end

   assign bit_num  = EW'({scan_word_ff, zpos});
   assign free_hit = mem_rdata[idx_ff[BW-1:0]];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bia_pkg::ST_CLEAR: begin
            if (clr_cnt_ff == '1) begin
               state_in = bia_pkg::ST_IDLE;
            end
         end
         bia_pkg::ST_IDLE: begin
            if (start) begin
               if (req.cmd == bia_pkg::CMD_ALLOC && req.lim != '0) begin
                  state_in = bia_pkg::ST_SCAN;
               end else if (req.cmd == bia_pkg::CMD_FREE && req_in_range) begin
                  state_in = bia_pkg::ST_FCHK;
               end
            end
         end
         bia_pkg::ST_SCAN: begin
            if (found || at_last) begin
               state_in = bia_pkg::ST_IDLE;
            end
         end
         bia_pkg::ST_FCHK: begin
            state_in = bia_pkg::ST_IDLE;
         end
         default: begin
            state_in = bia_pkg::ST_IDLE;
         end
      endcase
   end

   // pool whose used count a completion updates
   assign done_pool = (state_ff == bia_pkg::ST_IDLE) ? req.pool : pool_ff;

   // datapath and memory control
   always_comb begin
      clr_cnt_in   = clr_cnt_ff;
      cmd_in       = cmd_ff;
      pool_in      = pool_ff;
      idx_in       = idx_ff;
      lim_in       = lim_ff;
      scan_word_in = scan_word_ff;
      mem_raddr    = {pool_ff, scan_word_ff + ADDR_W'(1)};
      mem_we       = 1'b0;
      mem_waddr    = {pool_ff, scan_word_ff};
      mem_wdata    = mem_rdata;
      done         = 1'b0;
      done_failed  = 1'b1;
      done_granted = '0;
      done_lim     = lim_ff;
      used_new     = used_old;

      unique case (state_ff)
         bia_pkg::ST_CLEAR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_cnt_ff;
            mem_wdata  = '0;
            clr_cnt_in = clr_cnt_ff + (ADDR_W + 1)'(1);
         end
         bia_pkg::ST_IDLE: begin
            cmd_in       = req.cmd;
            pool_in      = req.pool;
            idx_in       = req_idx;
            lim_in       = req.lim;
            scan_word_in = '0;
            done_lim     = req.lim;
            if (req.cmd == bia_pkg::CMD_ALLOC) begin
               mem_raddr = {req.pool, ADDR_W'(0)};
            end else begin
               mem_raddr = {req.pool, ADDR_W'(req_idx >> BW)};
            end
            // empty pool or bad free number: answer at once, no state change
            if (start) begin
               if (req.cmd == bia_pkg::CMD_ALLOC) begin
                  done = req.lim == '0;
               end else begin
                  done = !req_in_range;
               end
            end
         end
         bia_pkg::ST_SCAN: begin
            scan_word_in = scan_word_ff + ADDR_W'(1);
            if (found) begin
               mem_we       = 1'b1;
               mem_wdata    = mem_rdata | (WB'(1) << zpos);
               done         = 1'b1;
               done_failed  = 1'b0;
               done_granted = (pool_ff == bia_pkg::POOL_BLOCK) ? bit_num : bit_num + EW'(1);
               used_new     = used_old + EW'(1);
            end else if (at_last) begin
               done = 1'b1;
            end
         end
         bia_pkg::ST_FCHK: begin
            mem_waddr = {pool_ff, ADDR_W'(idx_ff >> BW)};
            mem_wdata = mem_rdata & ~(WB'(1) << idx_ff[BW-1:0]);
            done      = 1'b1;
            if (free_hit) begin
               mem_we      = 1'b1;
               done_failed = 1'b0;
               if (used_old != '0) begin
                  used_new = used_old - EW'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign used_old = (done_pool == bia_pkg::POOL_BLOCK) ? block_used_ff : inode_used_ff;

   always_comb begin
      inode_used_in = inode_used_ff;
      block_used_in = block_used_ff;
      if (done) begin
         if (done_pool == bia_pkg::POOL_BLOCK) begin
            block_used_in = used_new;
         end else begin
            inode_used_in = used_new;
         end
      end
      rsp_in.valid    = done;
      rsp_in.granted  = done_granted;
      rsp_in.failed   = done_failed;
      rsp_in.free_rem = (done_lim > used_new) ? done_lim - used_new : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bia_pkg::ST_CLEAR;
         clr_cnt_ff    <= '0;
         inode_used_ff <= '0;
         block_used_ff <= '0;
         rsp_ff.valid  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         inode_used_ff <= inode_used_in;
         block_used_ff <= block_used_in;
         rsp_ff.valid  <= rsp_in.valid;
      end
      rsp_ff.granted  <= rsp_in.granted;
      rsp_ff.failed   <= rsp_in.failed;
      rsp_ff.free_rem <= rsp_in.free_rem;
   end

   always_ff @(posedge clock) begin
      cmd_ff          <= cmd_in;
      pool_ff         <= pool_in;
      idx_ff          <= idx_in;
      lim_ff          <= lim_in;
      scan_word_ff    <= scan_word_in;
   end

   assign busy = state_ff != bia_pkg::ST_IDLE;
   assign rsp  = rsp_ff;

`ifndef ASSERT_OFF
   a_reset_clears: assert property (@(posedge clock)
      reset |=> state_ff == bia_pkg::ST_CLEAR)
      else $error("reset did not start the clearing pass");

   a_write_owner: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> state_ff != bia_pkg::ST_IDLE)
      else $error("map write while idle");

   a_success_wrote: assert property (@(posedge clock) disable iff (reset)
      rsp_ff.valid && !rsp_ff.failed |-> $past(mem_we))
      else $error("successful request left the map unchanged");

   a_fail_no_grant: assert property (@(posedge clock) disable iff (reset)
      rsp_ff.valid && (rsp_ff.failed || cmd_ff == bia_pkg::CMD_FREE)
      |-> rsp_ff.granted == '0)
      else $error("number granted on a failed or free request");

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      32'(inode_used_ff) <= MAP_BITS && 32'(block_used_ff) <= MAP_BITS)
      else $error("used count beyond map size");
`endif

endmodule

FILE: bench/tb_bitmap_inode_block_allocator_top.sv
`timescale 1ns / 1ps

module tb_bitmap_inode_block_allocator_top;

   localparam int unsigned ENTRY_W = bia_pkg::ENTRY_W;
   localparam int unsigned MAP_ENTRIES = 8192;
   localparam int unsigned CYCLE_LIMIT = 1500000;
   // longest allocate scan is 256 words, plus margin for the response
   localparam int unsigned SETTLE_CYCLES = 300;
   localparam int unsigned IDLE_PCT = 9;

   typedef struct {
      logic               cmd;
      logic               pool;
      logic [ENTRY_W-1:0] entry;
   } alloc_request_type;

   typedef struct {
      logic [ENTRY_W-1:0] granted;
      logic               failed;
      logic [ENTRY_W-1:0] free_rem;
   } alloc_outcome_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic               req_command = bia_pkg::CMD_ALLOC;
   logic               req_pool = bia_pkg::POOL_INODE;
   logic [ENTRY_W-1:0] req_entry_number = '0;
   logic               rsp_valid;
   logic [ENTRY_W-1:0] rsp_granted_number;
   logic               rsp_failed;
   logic [ENTRY_W-1:0] rsp_free_remaining;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic               csr_index = bia_pkg::CSR_INODE_LIMIT;
   logic [ENTRY_W-1:0] csr_wdata = '0;

   // Shadow of the allocator: one bitmap and one used count per pool,
   // indexed by the pool code, plus the two limit registers.
   bit                 in_use [2][MAP_ENTRIES];
   int unsigned        taken [2] = '{0, 0};
   logic [ENTRY_W-1:0] limit_reg [2];

   alloc_request_type pending_requests [$];
   alloc_outcome_type expected_outcomes [$];

   bit          quiet_stretch = 1'b0;
   int unsigned mismatches = 0;
   int unsigned cycle_count = 0;
   int unsigned grants = 0;
   int unsigned refusals = 0;
   int unsigned releases = 0;
   int unsigned rejected_frees = 0;
   int unsigned limit_writes = 0;
   int unsigned phases = 0;

   bitmap_inode_block_allocator_top #(
      .MAP_BITS(MAP_ENTRIES)
   ) DUT (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_command        (req_command),
      .req_pool           (req_pool),
      .req_entry_number   (req_entry_number),
      .rsp_valid          (rsp_valid),
      .rsp_granted_number (rsp_granted_number),
      .rsp_failed         (rsp_failed),
      .rsp_free_remaining (rsp_free_remaining),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Apply one request to the shadow maps and return what the block must answer.
   function automatic alloc_outcome_type predict_outcome(alloc_request_type r);
      int unsigned       lim;
      int unsigned       slot;
      bit                in_range;
      alloc_outcome_type o;
      // limits above the map size act as the map size
      lim = (limit_reg[r.pool] > MAP_ENTRIES) ? MAP_ENTRIES : 32'(limit_reg[r.pool]);
      o.granted = '0;
      o.failed = 1'b1;
      if (r.cmd == bia_pkg::CMD_ALLOC) begin
         // first fit: lowest clear bit below the limit
         slot = 0;
         while (slot < lim && in_use[r.pool][slot])
            slot++;
         if (slot < lim) begin
            in_use[r.pool][slot] = 1'b1;
            taken[r.pool]++;
            o.granted = (r.pool == bia_pkg::POOL_BLOCK) ? ENTRY_W'(slot) : ENTRY_W'(slot + 1);
            o.failed = 1'b0;
            grants++;
         end else begin
            refusals++;
         end
      end else begin
         // inode numbers count from one, block numbers from zero
         if (r.pool == bia_pkg::POOL_BLOCK) begin
            in_range = 32'(r.entry) < lim;
            slot = 32'(r.entry);
         end else begin
            in_range = r.entry != '0 && 32'(r.entry) <= lim;
            slot = 32'(r.entry) - 1;
         end
         // out of range or already clear: flag it and leave the map alone
         if (in_range && in_use[r.pool][slot]) begin
            in_use[r.pool][slot] = 1'b0;
            if (taken[r.pool] > 0)
               taken[r.pool]--;
            o.failed = 1'b0;
            releases++;
         end else begin
            rejected_frees++;
         end
      end
      // entries stranded above a lowered limit still count, so floor at zero
      o.free_rem = (lim > taken[r.pool]) ? ENTRY_W'(lim - taken[r.pool]) : '0;
      return o;
   endfunction

   // Request driver: predict on each accepted request, then either hold the
   // next request on the ports or drop start for an idle cycle.
   always @(posedge clock) begin : request_driver
      alloc_request_type accepted;
      alloc_request_type next_req;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            accepted.cmd = req_command;
            accepted.pool = req_pool;
            accepted.entry = req_entry_number;
            expected_outcomes.push_back(predict_outcome(accepted));
         end
         // hold while a request waits on busy; otherwise advance
         if (!start || !busy) begin
            if (pending_requests.size() != 0 &&
                (quiet_stretch || $urandom_range(0, 99) >= IDLE_PCT)) begin
               next_req = pending_requests.pop_front();
               start <= 1'b1;
               req_command <= next_req.cmd;
               req_pool <= next_req.pool;
               req_entry_number <= next_req.entry;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Response monitor: the strobe cannot be stalled, so check on every pulse.
   always @(posedge clock) begin : response_monitor
      alloc_outcome_type want;
      if (!reset && rsp_valid) begin
         if (expected_outcomes.size() == 0) begin
            $error("response with no request outstanding: granted %0d failed %0b free %0d",
                   rsp_granted_number, rsp_failed, rsp_free_remaining);
            mismatches++;
         end else begin
            want = expected_outcomes.pop_front();
            if (rsp_granted_number !== want.granted) begin
               $error("granted_number: expected %0d, got %0d", want.granted,
                      rsp_granted_number);
               mismatches++;
            end
            if (rsp_failed !== want.failed) begin
               $error("failed: expected %0b, got %0b", want.failed, rsp_failed);
               mismatches++;
            end
            if (rsp_free_remaining !== want.free_rem) begin
               $error("free_remaining: expected %0d, got %0d", want.free_rem,
                      rsp_free_remaining);
               mismatches++;
            end
         end
      end
   end

   // Watchdog: a hung block must not stall the run forever.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding", cycle_count,
                  expected_outcomes.size());
         $display("bitmap_inode_block_allocator_top verification failed");
         $finish;
      end
   end

   // Wait until every queued request has been issued and answered.
   task automatic drain();
      while (pending_requests.size() != 0 || start || busy || expected_outcomes.size() != 0)
         @(posedge clock);
   endtask

   // Issue one limit write; valid stays high for the caller to drop.
   task automatic write_limit(input logic idx, input logic [ENTRY_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      limit_reg[idx] = value;
      limit_writes++;
   endtask

   // Change both limits with nothing in flight.
   task automatic set_limits(input logic [ENTRY_W-1:0] inode_lim,
                             input logic [ENTRY_W-1:0] block_lim);
      drain();
      write_limit(bia_pkg::CSR_INODE_LIMIT, inode_lim);
      write_limit(bia_pkg::CSR_BLOCK_LIMIT, block_lim);
      csr_valid <= 1'b0;
      phases++;
   endtask

   task automatic queue_request(input logic cmd, input logic pool,
                                input logic [ENTRY_W-1:0] entry);
      alloc_request_type r;
      r.cmd = cmd;
      r.pool = pool;
      r.entry = entry;
      pending_requests.push_back(r);
   endtask

   // Frees mostly aimed near the live part of the map, with some full-range noise.
   task automatic random_phase(input int unsigned count, input int unsigned alloc_pct);
      alloc_request_type r;
      int unsigned       n;
      int unsigned       lim;
      int unsigned       span;
      for (n = 0; n < count; n++) begin
         r.pool = 1'($urandom_range(0, 1));
         r.cmd = ($urandom_range(0, 99) < alloc_pct) ? bia_pkg::CMD_ALLOC : bia_pkg::CMD_FREE;
         lim = (limit_reg[r.pool] > MAP_ENTRIES) ? MAP_ENTRIES : 32'(limit_reg[r.pool]);
         span = ((lim > 80) ? 80 : lim) + 2;
         if (r.cmd == bia_pkg::CMD_ALLOC || $urandom_range(0, 99) < 8)
            r.entry = ENTRY_W'($urandom_range(0, (1 << ENTRY_W) - 1));
         else
            r.entry = ENTRY_W'($urandom_range(0, span));
         pending_requests.push_back(r);
      end
   endtask

   initial begin : stimulus
      int unsigned p;
      limit_reg[0] = bia_pkg::LIMIT_RESET;
      limit_reg[1] = bia_pkg::LIMIT_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Tiny pools: fill both, overflow, free, double free and out-of-range frees.
      set_limits(14'd4, 14'd3);
      queue_request(bia_pkg::CMD_FREE, bia_pkg::POOL_INODE, 14'd0);
      queue_request(bia_pkg::CMD_FREE, bia_pkg::POOL_BLOCK, 14'd0);
      repeat (5) queue_request(bia_pkg::CMD_ALLOC, bia_pkg::POOL_INODE, 14'd0);
      repeat (4) queue_request(bia_pkg::CMD_ALLOC, bia_pkg::POOL_BLOCK, 14'h1555);
      queue_request(bia_pkg::CMD_FREE, bia_pkg::POOL_INODE, 14'd4);
      queue_request(bia_pkg::CMD_FREE, bia_pkg::POOL_INODE, 14'd4);
      queue_request(bia_pkg::CMD_FREE, bia_pkg::POOL_INODE, 14'd5);
      queue_request(bia_pkg::CMD_FREE, bia_pkg::POOL_BLOCK, 14'd2);
      queue_request(bia_pkg::CMD_FREE, bia_pkg::POOL_BLOCK, 14'd3);
      queue_request(bia_pkg::CMD_ALLOC, bia_pkg::POOL_BLOCK, 14'h3FFF);
      queue_request(bia_pkg::CMD_FREE, bia_pkg::POOL_INODE, 14'h3FFF);
      queue_request(bia_pkg::CMD_FREE, bia_pkg::POOL_BLOCK, 14'h2AAA);

      // Empty inode pool; block limit above the map size saturates.
      set_limits(14'd0, 14'h3FFF);
      queue_request(bia_pkg::CMD_ALLOC, bia_pkg::POOL_INODE, 14'd0);
      queue_request(bia_pkg::CMD_FREE, bia_pkg::POOL_INODE, 14'd1);
      queue_request(bia_pkg::CMD_ALLOC, bia_pkg::POOL_BLOCK, 14'd0);
      queue_request(bia_pkg::CMD_FREE, bia_pkg::POOL_BLOCK, 14'd8191);
      queue_request(bia_pkg::CMD_FREE, bia_pkg::POOL_BLOCK, 14'd8192);

      // Inode limit below the inodes in use: stranded entries, floored count.
      set_limits(14'd2, 14'd8192);
      queue_request(bia_pkg::CMD_ALLOC, bia_pkg::POOL_INODE, 14'd0);
      queue_request(bia_pkg::CMD_FREE, bia_pkg::POOL_INODE, 14'd3);
      queue_request(bia_pkg::CMD_FREE, bia_pkg::POOL_INODE, 14'd2);

      // Random phases over a spread of limits; maps carry over between phases.
      for (p = 0; p < 10; p++) begin
         case (p)
            0: set_limits(ENTRY_W'($urandom_range(1, 8)), ENTRY_W'($urandom_range(1, 8)));
            1: set_limits(ENTRY_W'($urandom_range(9, 40)), ENTRY_W'($urandom_range(9, 40)));
            2: set_limits(14'd0, ENTRY_W'($urandom_range(1, 30)));
            4: set_limits(14'd1, 14'd2);
            5: set_limits(14'd8192, ENTRY_W'($urandom_range(8193, 16383)));
            6: set_limits(ENTRY_W'($urandom_range(200, 600)),
                          ENTRY_W'($urandom_range(200, 600)));
            8: set_limits(14'd250, 14'd250);
            9: set_limits(ENTRY_W'($urandom_range(0, 16383)),
                          ENTRY_W'($urandom_range(0, 16383)));
            default: set_limits(ENTRY_W'($urandom_range(1, 64)),
                                ENTRY_W'($urandom_range(1, 64)));
         endcase
         // one phase back to back with no gaps at all
         quiet_stretch = (p == 3);
         if (p == 8)
            random_phase(250, 85);
         else
            random_phase(90, 55);
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_outcomes.size() != 0) begin
         $error("%0d responses never arrived", expected_outcomes.size());
         mismatches++;
      end

      $display("covered %0d grants, %0d full-pool refusals, %0d frees, %0d rejected frees",
               grants, refusals, releases, rejected_frees);
      $display("across %0d limit settings (%0d register writes), zero and saturated included",
               phases, limit_writes);
      if (mismatches == 0) begin
         $display("bitmap_inode_block_allocator_top verification clean");
      end else begin
         $display("bitmap_inode_block_allocator_top verification failed");
      end
      $finish;
   end

endmodule
